FILE: hdl/rsq_pkg.sv
// Package for the range max/min spread query unit.
// Field widths, command and status codes, queue op type, priority encoder.
// No dependencies.
package rsq_pkg;

	localparam int MAX_ELEMENTS_DEF = 1024;
	localparam int LEVELS_DEF       = 11;
	localparam int VALUE_BITS_DEF   = 32;
	localparam int QUEUE_DEPTH      = 4;

	localparam int CMD_W       = 2;
	localparam int VALUE_W     = 32;
	localparam int IDX_FIELD_W = 10;
	localparam int SPREAD_W    = 32;
	localparam int STATUS_W    = 2;
	localparam int LOG_IN_W    = 17;
	localparam int LOG_OUT_W   = 5;

	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_QUERY,
		OP_ERR
	} op_kind_t;

	typedef struct packed {
		op_kind_t               kind;
		logic [STATUS_W-1:0]    status;
	} rsq_op_t;

	// floor(log2(x)) for x > 0; highest set bit wins
	function automatic logic [LOG_OUT_W-1:0] flog2(input logic [LOG_IN_W-1:0] x);
		logic [LOG_OUT_W-1:0] r;
		r = '0;
		for (int i = 0; i < LOG_IN_W; i++) begin
			if (x[i]) begin
				r = LOG_OUT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

FILE: hdl/rsq_ram.sv
// Generic simple RAM: one write port, two read ports, registered read data.
// No dependencies.
module rsq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: hdl/rsq_queue.sv
// Small FIFO of decoded ops between the front and the back.
// No package dependencies.
module rsq_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: hdl/rsq_front.sv
// Front end: accepts input transfers, tracks the element count, checks ranges
// and works out table levels and window starts. Depends on rsq_pkg.
module rsq_front import rsq_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int LEVELS       = LEVELS_DEF,
	parameter int VALUE_BITS   = VALUE_BITS_DEF,
	localparam int IDX_W = $clog2(MAX_ELEMENTS),
	localparam int LVL_W = $clog2(LEVELS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [CMD_W-1:0]             command,
	input  logic signed [VALUE_W-1:0]    value,
	input  logic [IDX_FIELD_W-1:0]       left,
	input  logic [IDX_FIELD_W-1:0]       right,
	input  logic                         full,
	output logic                         push,
	output rsq_op_t                      op,
	output logic signed [VALUE_BITS-1:0] op_value,
	output logic [IDX_W-1:0]             op_idx_a,
	output logic [IDX_W-1:0]             op_idx_b,
	output logic [LVL_W-1:0]             op_lvl
);

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int QW    = (CNT_W > IDX_FIELD_W) ? CNT_W : IDX_FIELD_W;
	localparam int IW    = (IDX_W > IDX_FIELD_W) ? IDX_W : IDX_FIELD_W;
	localparam int LW    = IDX_FIELD_W + 1;
	localparam logic [LOG_OUT_W-1:0] TOP_LVL = LOG_OUT_W'(LEVELS - 1);

	logic [CNT_W-1:0]     count_q;
	logic                 accept;
	logic                 store_full;
	logic                 bad_range;
	logic [LOG_OUT_W-1:0] load_log, query_log, query_k;
	logic [LW-1:0]        len, second;
	logic [IW-1:0]        left_w, second_w;

	assign in_stall   = full;
	assign accept     = in_valid && !full;
	assign store_full = (count_q == CNT_W'(MAX_ELEMENTS));

	// new value at index count closes windows up to floor(log2(count+1))
	assign load_log = flog2(LOG_IN_W'(count_q) + LOG_IN_W'(1));

	assign bad_range = (left > right) || (QW'(right) >= QW'(count_q));
	assign len       = LW'(right) - LW'(left) + LW'(1);
	assign query_log = flog2(LOG_IN_W'(len));
	assign query_k   = (query_log > TOP_LVL) ? TOP_LVL : query_log;
	assign second    = LW'(right) + LW'(1) - (LW'(1) << query_k);
	assign left_w    = IW'(left);
	assign second_w  = IW'(second[IDX_FIELD_W-1:0]);

	always_comb begin
		push       = 1'b0;
		op.kind    = OP_LOAD;
		op.status  = STATUS_OK;
		op_value   = VALUE_BITS'(value);
		op_idx_a   = count_q[IDX_W-1:0];
		op_idx_b   = second_w[IDX_W-1:0];
		op_lvl     = LVL_W'((load_log > TOP_LVL) ? TOP_LVL : load_log);
		case (command)
			CMD_APPEND: begin
				push = accept;
				if (store_full) begin
					op.kind   = OP_ERR;
					op.status = STATUS_FULL;
				end
			end
			CMD_QUERY: begin
				push     = accept;
				op_idx_a = left_w[IDX_W-1:0];
				op_lvl   = LVL_W'(query_k);
				if (bad_range) begin
					op.kind   = OP_ERR;
					op.status = STATUS_BAD_RANGE;
				end else begin
					op.kind = OP_QUERY;
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			case (command)
				CMD_APPEND: begin
					if (!store_full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				CMD_CLEAR: count_q <= '0;
				default:   count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hdl/rsq_back.sv
// Back end: runs queued ops against the max and min sparse tables and holds
// the output register. Depends on rsq_pkg and rsq_ram.
module rsq_back import rsq_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int LEVELS       = LEVELS_DEF,
	parameter int VALUE_BITS   = VALUE_BITS_DEF,
	localparam int IDX_W = $clog2(MAX_ELEMENTS),
	localparam int LVL_W = $clog2(LEVELS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  rsq_op_t                      q_op,
	input  logic signed [VALUE_BITS-1:0] q_value,
	input  logic [IDX_W-1:0]             q_idx_a,
	input  logic [IDX_W-1:0]             q_idx_b,
	input  logic [LVL_W-1:0]             q_lvl,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [SPREAD_W-1:0]          spread,
	output logic [STATUS_W-1:0]          status
);

	localparam int TD = LEVELS * (2 ** IDX_W);
	localparam int AW = LVL_W + IDX_W;
	localparam int PW = IDX_W + 1;
	localparam int DW = ((VALUE_BITS > SPREAD_W) ? VALUE_BITS : SPREAD_W) + 1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LOAD0 = 6'b000010,
		ST_LSTEP = 6'b000100,
		ST_QREAD = 6'b001000,
		ST_QCMP  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t                       state_q;
	logic [IDX_W-1:0]             p_q, ib_q;
	logic signed [VALUE_BITS-1:0] v_q, mx_q, mn_q;
	logic [LVL_W-1:0]             lvl_q, j_q, jn;
	logic [STATUS_W-1:0]          st_q;
	logic                         out_valid_q;
	logic [SPREAD_W-1:0]          spread_q;
	logic [STATUS_W-1:0]          status_q;

	logic                         out_free;
	logic                         load_state;
	logic [PW-1:0]                p_inc, rd_start, wr_start;
	logic                         we;
	logic [AW-1:0]                waddr, raddr_a, raddr_b;
	logic [VALUE_BITS-1:0]        wdata_max, wdata_min;
	logic [VALUE_BITS-1:0]        rd_max_a, rd_max_b, rd_min_a, rd_min_b;
	logic signed [VALUE_BITS-1:0] smax_a, smax_b, smin_a, smin_b;
	logic signed [VALUE_BITS-1:0] step_max, step_min, q_hi, q_lo;
	logic signed [DW-1:0]         diff;

	assign out_free   = !out_valid_q || !out_stall;
	assign load_state = (state_q == ST_LOAD0) || (state_q == ST_LSTEP);
	assign q_pop      = (state_q == ST_IDLE) && q_valid;

	// level j window ending at p starts at p+1-2^j; its left half is read from level j-1,
	// the right half is the running result of the step before
	assign jn       = (state_q == ST_LSTEP) ? j_q + LVL_W'(1) : j_q;
	assign p_inc    = PW'(p_q) + PW'(1);
	assign rd_start = p_inc - (PW'(1) << jn);
	assign wr_start = p_inc - (PW'(1) << j_q);

	assign raddr_a = load_state ? {jn - LVL_W'(1), rd_start[IDX_W-1:0]} : {lvl_q, p_q};
	assign raddr_b = {lvl_q, ib_q};

	assign smax_a = rd_max_a;
	assign smax_b = rd_max_b;
	assign smin_a = rd_min_a;
	assign smin_b = rd_min_b;

	assign step_max = (smax_a > mx_q) ? smax_a : mx_q;
	assign step_min = (smin_a < mn_q) ? smin_a : mn_q;
	assign q_hi     = (smax_a > smax_b) ? smax_a : smax_b;
	assign q_lo     = (smin_a < smin_b) ? smin_a : smin_b;

	assign we        = load_state;
	assign waddr     = (state_q == ST_LOAD0) ? {LVL_W'(0), p_q} : {j_q, wr_start[IDX_W-1:0]};
	assign wdata_max = (state_q == ST_LOAD0) ? v_q : step_max;
	assign wdata_min = (state_q == ST_LOAD0) ? v_q : step_min;

	assign diff = DW'(mx_q) - DW'(mn_q);

	rsq_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(TD)
	) u_max_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata_max),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rd_max_a),
		.rdata_b(rd_max_b)
	);

	rsq_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(TD)
	) u_min_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata_min),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rd_min_a),
		.rdata_b(rd_min_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						case (q_op.kind)
							OP_LOAD:  state_q <= ST_LOAD0;
							OP_QUERY: state_q <= ST_QREAD;
							default:  state_q <= ST_OUT;
						endcase
					end
				end
				ST_LOAD0: state_q <= (lvl_q == '0) ? ST_IDLE : ST_LSTEP;
				ST_LSTEP: begin
					if (j_q == lvl_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QREAD: state_q <= ST_QCMP;
				ST_QCMP:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase

			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				p_q   <= q_idx_a;
				ib_q  <= q_idx_b;
				v_q   <= q_value;
				lvl_q <= q_lvl;
				st_q  <= q_op.status;
				j_q   <= LVL_W'(1);
				mx_q  <= '0;
				mn_q  <= '0;
			end
			ST_LOAD0: begin
				mx_q <= v_q;
				mn_q <= v_q;
			end
			ST_LSTEP: begin
				mx_q <= step_max;
				mn_q <= step_min;
				j_q  <= j_q + LVL_W'(1);
			end
			ST_QCMP: begin
				mx_q <= q_hi;
				mn_q <= q_lo;
			end
			default: begin
				mx_q <= mx_q;
			end
		endcase

		if ((state_q == ST_OUT) && out_free) begin
			spread_q <= diff[SPREAD_W-1:0];
			status_q <= st_q;
		end
	end

	assign out_valid = out_valid_q;
	assign spread    = spread_q;
	assign status    = status_q;

endmodule

FILE: hdl/range_max_min_spread_query_unit.sv
// Top level of the range max/min spread query unit: front, op queue, back.
// Depends on rsq_pkg, rsq_front, rsq_queue, rsq_back (and rsq_ram below it).
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------
//  input   | in_valid / in_stall | command, value, left, right
//  output  | out_valid/out_stall | spread, status
//
// The front takes one transfer per cycle while the op queue has room; clear
// and unused commands finish there. The back runs one op at a time: an append
// writes level 0, then one level per cycle through each table's single write
// port, up to min(floor(log2(index+1)), LEVELS-1). A query passes the read,
// compare and output states, an error only the output; output waits on a stall.
// Reset empties the queue and the count; table memories are not cleared.
// in_stall is high only while the queue is full.
module range_max_min_spread_query_unit import rsq_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
	parameter int LEVELS       = LEVELS_DEF,
	parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [CMD_W-1:0]          command,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [IDX_FIELD_W-1:0]    left,
	input  logic [IDX_FIELD_W-1:0]    right,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [SPREAD_W-1:0]       spread,
	output logic [STATUS_W-1:0]       status
);

	localparam int IDX_W = $clog2(MAX_ELEMENTS);
	localparam int LVL_W = $clog2(LEVELS);
	localparam int QD_W  = $bits(rsq_op_t) + VALUE_BITS + 2 * IDX_W + LVL_W;

	logic                         q_push, q_full, q_pop, q_valid;
	rsq_op_t                      f_op, q_op;
	logic signed [VALUE_BITS-1:0] f_value, q_value;
	logic [IDX_W-1:0]             f_idx_a, f_idx_b, q_idx_a, q_idx_b;
	logic [LVL_W-1:0]             f_lvl, q_lvl;
	logic [QD_W-1:0]              q_head;

	rsq_front #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.LEVELS      (LEVELS),
		.VALUE_BITS  (VALUE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command (command),
		.value   (value),
		.left    (left),
		.right   (right),
		.full    (q_full),
		.push    (q_push),
		.op      (f_op),
		.op_value(f_value),
		.op_idx_a(f_idx_a),
		.op_idx_b(f_idx_b),
		.op_lvl  (f_lvl)
	);

	rsq_queue #(
		.WIDTH(QD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_op, f_value, f_idx_a, f_idx_b, f_lvl}),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_data (q_head)
	);

	assign {q_op, q_value, q_idx_a, q_idx_b, q_lvl} = q_head;

	rsq_back #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.LEVELS      (LEVELS),
		.VALUE_BITS  (VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_op     (q_op),
		.q_value  (q_value),
		.q_idx_a  (q_idx_a),
		.q_idx_b  (q_idx_b),
		.q_lvl    (q_lvl),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.spread   (spread),
		.status   (status)
	);

`ifndef SYNTH
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("op queue popped while empty");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("op queue pushed while full");

	a_load_level: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && (q_op.kind == OP_LOAD)) |-> (q_lvl <= LVL_W'(LEVELS - 1)))
		else $error("append op carries a level beyond the table");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && (q_op.kind == OP_ERR)) |-> (q_op.status != STATUS_OK))
		else $error("error op without an error status");
`endif

endmodule
